FILE: hdl/multilevel_priority_fifo_top_macros.svh
// Assertion macros for the multilevel priority FIFO.
// Included by the top level; no other dependencies.
`ifndef MULTILEVEL_PRIORITY_FIFO_TOP_MACROS_SVH
`define MULTILEVEL_PRIORITY_FIFO_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define MLPF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MLPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MLPF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define MLPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hdl/mlpf_pkg.sv
// Shared types and constants for the multilevel priority FIFO.
// No dependencies.
package mlpf_pkg;

    localparam int PAYLOAD_W = 32;
    localparam int LEVEL_REQ_W = 4;
    localparam int TOTAL_W = 8;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef struct packed {
        logic                   operation;
        logic [LEVEL_REQ_W-1:0] priority_req;
        logic [PAYLOAD_W-1:0]   payload;
    } t_in_item;

    typedef struct packed {
        logic [PAYLOAD_W-1:0] removed_payload;
        logic [PAYLOAD_W-1:0] head_payload;
        logic                 queue_empty;
        logic [TOTAL_W-1:0]   total_count;
        t_status              status;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load_out;
    } t_fifo_cmd;

endpackage

FILE: hdl/mlpf_ram.sv
// Generic RAM: one write port, two registered read ports with enable.
// No dependencies.
module mlpf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 144
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_a,
    output logic [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data_a <= r_mem[i_rd_addr_a];
            o_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end

endmodule

FILE: hdl/mlpf_ctrl.sv
// Controller: sequences capture, execute and result load per item.
// Depends on mlpf_pkg.
module mlpf_ctrl
    import mlpf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_fifo_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   can_load;
    logic   in_ready;
    logic   accept;

    always_comb begin
        out_free = !r_out_valid || !i_out_stall;
        can_load = (r_state == S_DONE) && out_free;
        in_ready = (r_state == S_IDLE) || can_load;
        accept   = i_in_valid && in_ready;

        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (can_load) begin
                    n_state = accept ? S_EXEC : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (can_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall     = !in_ready;
    assign o_out_valid    = r_out_valid;
    assign o_cmd.capture  = accept;
    assign o_cmd.exec     = (r_state == S_EXEC);
    assign o_cmd.load_out = can_load;

endmodule

FILE: hdl/mlpf_dp.sv
// Datapath: level pointers, occupancy, entry RAM and result register.
// Depends on mlpf_pkg and mlpf_ram.
module mlpf_dp
    import mlpf_pkg::*;
#(
    parameter int NUM_LEVELS    = 9,
    parameter int LEVEL_DEPTH   = 16,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_fifo_cmd i_cmd,
    input  t_in_item  i_item,
    output t_out_item o_item
);

    localparam int PTR_W   = $clog2(LEVEL_DEPTH);
    localparam int CNT_W   = $clog2(LEVEL_DEPTH + 1);
    localparam int LVL_W   = $clog2(NUM_LEVELS);
    localparam int ENTRIES = NUM_LEVELS * LEVEL_DEPTH;
    localparam int ADDR_W  = $clog2(ENTRIES);
    localparam int STORE_W = (PAYLOAD_WIDTH < PAYLOAD_W) ? PAYLOAD_WIDTH : PAYLOAD_W;

    function automatic logic [PTR_W-1:0] f_wrap(input logic [PTR_W-1:0] p);
        f_wrap = (p == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    logic                   r_op;
    logic [LEVEL_REQ_W-1:0] r_lvl;
    logic [STORE_W-1:0]     r_data;
    logic [PTR_W-1:0]       r_head [NUM_LEVELS];
    logic [PTR_W-1:0]       r_tail [NUM_LEVELS];
    logic [CNT_W-1:0]       r_cnt  [NUM_LEVELS];
    logic [PTR_W-1:0]       n_head [NUM_LEVELS];
    logic [PTR_W-1:0]       n_tail [NUM_LEVELS];
    logic [CNT_W-1:0]       n_cnt  [NUM_LEVELS];
    logic [TOTAL_W-1:0]     r_total, n_total;
    logic                   r_rem_ok;
    logic                   r_bypass;
    logic                   r_any;
    t_status                r_status, n_status;
    t_out_item              r_out;

    logic [LVL_W-1:0]  lvl_idx;
    logic              lvl_ok;
    logic              lvl_full;
    logic              ins_ok;
    logic              rem_ok;
    logic [LVL_W-1:0]  old_top;
    logic              old_any;
    logic [LVL_W-1:0]  new_top;
    logic              new_any;
    logic              bypass;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic [STORE_W-1:0] rd_data_a;
    logic [STORE_W-1:0] rd_data_b;

    always_comb begin
        lvl_idx  = r_lvl[LVL_W-1:0];
        lvl_ok   = ({1'b0, r_lvl} < (LEVEL_REQ_W + 1)'(NUM_LEVELS));
        lvl_full = (r_cnt[lvl_idx] == CNT_W'(LEVEL_DEPTH));

        old_top = '0;
        old_any = 1'b0;
        for (int l = 0; l < NUM_LEVELS; l++) begin
            if (r_cnt[l] != '0) begin
                old_top = LVL_W'(l);
                old_any = 1'b1;
            end
        end

        ins_ok = (r_op == OP_INSERT) && lvl_ok && !lvl_full;
        rem_ok = (r_op == OP_REMOVE) && old_any;

        n_head = r_head;
        n_tail = r_tail;
        n_cnt  = r_cnt;
        if (ins_ok) begin
            n_tail[lvl_idx] = f_wrap(r_tail[lvl_idx]);
            n_cnt[lvl_idx]  = r_cnt[lvl_idx] + CNT_W'(1);
        end
        if (rem_ok) begin
            n_head[old_top] = f_wrap(r_head[old_top]);
            n_cnt[old_top]  = r_cnt[old_top] - CNT_W'(1);
        end

        new_top = '0;
        new_any = 1'b0;
        for (int l = 0; l < NUM_LEVELS; l++) begin
            if (n_cnt[l] != '0) begin
                new_top = LVL_W'(l);
                new_any = 1'b1;
            end
        end

        bypass  = ins_ok && (r_cnt[lvl_idx] == '0) && (new_top == lvl_idx);
        n_total = r_total + TOTAL_W'(ins_ok) - TOTAL_W'(rem_ok);

        if ((r_op == OP_INSERT) && !ins_ok) begin
            n_status = ST_OVERFLOW;
        end else if ((r_op == OP_REMOVE) && !rem_ok) begin
            n_status = ST_UNDERFLOW;
        end else begin
            n_status = ST_OK;
        end

        wr_addr   = ADDR_W'(int'(lvl_idx) * LEVEL_DEPTH + int'(r_tail[lvl_idx]));
        rd_addr_a = ADDR_W'(int'(old_top) * LEVEL_DEPTH + int'(r_head[old_top]));
        rd_addr_b = ADDR_W'(int'(new_top) * LEVEL_DEPTH + int'(n_head[new_top]));
    end

    mlpf_ram #(
        .WIDTH (STORE_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (i_cmd.exec && ins_ok),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (r_data),
        .i_rd_en     (i_cmd.exec),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_item.operation;
            r_lvl  <= i_item.priority_req;
            r_data <= i_item.payload[STORE_W-1:0];
        end
        if (i_cmd.exec) begin
            r_rem_ok <= rem_ok;
            r_bypass <= bypass;
            r_any    <= new_any;
            r_status <= n_status;
        end
        if (i_cmd.load_out) begin
            r_out.removed_payload <= r_rem_ok ? PAYLOAD_W'(rd_data_a) : '0;
            r_out.head_payload    <= !r_any    ? '0 :
                                     r_bypass  ? PAYLOAD_W'(r_data) :
                                                 PAYLOAD_W'(rd_data_b);
            r_out.queue_empty     <= !r_any;
            r_out.total_count     <= r_total;
            r_out.status          <= r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
                r_head[l] <= '0;
                r_tail[l] <= '0;
                r_cnt[l]  <= '0;
            end
            r_total <= '0;
        end else if (i_cmd.exec) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_cnt   <= n_cnt;
            r_total <= n_total;
        end
    end

    assign o_item = r_out;

endmodule

FILE: hdl/multilevel_priority_fifo_top.sv
// Multilevel priority FIFO top level: controller, datapath and checks.
// Depends on mlpf_pkg, mlpf_ctrl, mlpf_dp and the assertion macro header.
//
//   Channel | Direction | Handshake                   | Payload
//   in      | input     | i_in_valid / o_in_stall     | i_in_item  (t_in_item)
//   out     | output    | o_out_valid / i_out_stall   | o_out_item (t_out_item)
//
// Each item is first executed, which updates the level pointers, writes the entry
// RAM and issues both reads; the done state then waits for the registered RAM read.
// A new item is taken in the cycle its predecessor's result is loaded, so
// no new item is taken while an item is still executing.
// A stalled output holds the result register and then stalls the input.
// Reset clears all level pointers and counts; the entry RAM is not cleared.
`include "multilevel_priority_fifo_top_macros.svh"

module multilevel_priority_fifo_top
    import mlpf_pkg::*;
#(
    parameter int NUM_LEVELS    = 9,
    parameter int LEVEL_DEPTH   = 16,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_fifo_cmd cmd;

    mlpf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    mlpf_dp #(
        .NUM_LEVELS    (NUM_LEVELS),
        .LEVEL_DEPTH   (LEVEL_DEPTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_item  (i_in_item),
        .o_item  (o_out_item)
    );

    `MLPF_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, cmd.capture, cmd.exec, "accepted item did not execute")
    `MLPF_ASSERT_NEXT(a_load_valid, i_clk, i_rst_n, cmd.load_out, o_out_valid, "loaded result not valid")
    `MLPF_ASSERT_SAME(a_empty_zero, i_clk, i_rst_n, o_out_valid && o_out_item.queue_empty, (o_out_item.head_payload == '0) && (o_out_item.total_count == '0), "empty queue with head or count")
    `MLPF_ASSERT_SAME(a_underflow, i_clk, i_rst_n, o_out_valid && (o_out_item.status == ST_UNDERFLOW), o_out_item.queue_empty && (o_out_item.removed_payload == '0), "underflow on non-empty queue")

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for multilevel_priority_fifo_top: directed and random
// insert/remove items, per-level queue predictor, randomized valid/stall idling.
// Depends on mlpf_pkg and the multilevel_priority_fifo_top RTL.
module testbench;
    import mlpf_pkg::*;

    localparam int NUM_LEVELS  = 9;
    localparam int LEVEL_DEPTH = 16;
    localparam int MAX_WAIT    = 18;
    localparam int RANDOM_REQS = 900;
    localparam int CYCLE_LIMIT = 300000;
    localparam int TAIL_CYCLES = 10;

    typedef struct {
        t_in_item item;
        bit       drain_first;
    } t_queue_request;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    t_queue_request request_backlog[$];
    t_out_item      predicted_results[$];
    logic [PAYLOAD_W-1:0] level_entries[NUM_LEVELS][$];

    int errors = 0;
    int items_accepted = 0;
    int results_seen = 0;
    int cycles = 0;
    int send_wait = 0;
    int stall_wait = 0;
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;
    t_out_item want;

    multilevel_priority_fifo_top #(
        .NUM_LEVELS(NUM_LEVELS),
        .LEVEL_DEPTH(LEVEL_DEPTH),
        .PAYLOAD_WIDTH(PAYLOAD_W)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_item(i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item(o_out_item)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    task automatic report(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    function automatic int draw_wait(input bit calm);
        if (calm) begin
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic int top_level();
        for (int lv = NUM_LEVELS - 1; lv >= 0; lv--) begin
            if (level_entries[lv].size() != 0) begin
                return lv;
            end
        end
        return -1;
    endfunction

    function automatic t_out_item apply_request(input t_in_item req);
        t_out_item res;
        int        top;
        int        total;
        int        lv;
        res = '0;
        res.status = ST_OK;
        lv = int'(req.priority_req);
        if (t_op'(req.operation) == OP_INSERT) begin
            if (lv >= NUM_LEVELS || level_entries[lv].size() >= LEVEL_DEPTH) begin
                res.status = ST_OVERFLOW;
            end else begin
                level_entries[lv].push_back(req.payload);
            end
        end else begin
            top = top_level();
            if (top < 0) begin
                res.status = ST_UNDERFLOW;
            end else begin
                res.removed_payload = level_entries[top].pop_front();
            end
        end
        top = top_level();
        res.queue_empty = (top < 0);
        if (top >= 0) begin
            res.head_payload = level_entries[top][0];
        end
        total = 0;
        for (int k = 0; k < NUM_LEVELS; k++) begin
            total += level_entries[k].size();
        end
        res.total_count = total[TOTAL_W-1:0];
        return res;
    endfunction

    task automatic add_request(input t_op op, input int lv, input logic [PAYLOAD_W-1:0] data,
                               input bit drain_first);
        t_queue_request r;
        r.item.operation = op;
        r.item.priority_req = lv[LEVEL_REQ_W-1:0];
        r.item.payload = data;
        r.drain_first = drain_first;
        request_backlog.push_back(r);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && o_in_stall)) begin
            if (i_in_valid) begin
                predicted_results.push_back(apply_request(i_in_item));
                items_accepted++;
            end
            if ($urandom_range(0, 39) == 0) begin
                send_calm = ~send_calm;
            end
            if (request_backlog.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (send_wait != 0) begin
                i_in_valid <= 1'b0;
                send_wait--;
            end else if (request_backlog[0].drain_first && results_seen != items_accepted) begin
                i_in_valid <= 1'b0;
            end else begin
                i_in_valid <= 1'b1;
                i_in_item <= request_backlog[0].item;
                void'(request_backlog.pop_front());
                send_wait = draw_wait(send_calm);
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen <= results_seen + 1;
                if (predicted_results.size() == 0) begin
                    report("result with nothing awaited");
                end else begin
                    want = predicted_results.pop_front();
                    if (o_out_item.removed_payload !== want.removed_payload)
                        report($sformatf("removed_payload got %h want %h",
                                         o_out_item.removed_payload, want.removed_payload));
                    if (o_out_item.head_payload !== want.head_payload)
                        report($sformatf("head_payload got %h want %h",
                                         o_out_item.head_payload, want.head_payload));
                    if (o_out_item.queue_empty !== want.queue_empty)
                        report($sformatf("queue_empty got %b want %b",
                                         o_out_item.queue_empty, want.queue_empty));
                    if (o_out_item.total_count !== want.total_count)
                        report($sformatf("total_count got %0d want %0d",
                                         o_out_item.total_count, want.total_count));
                    if (o_out_item.status !== want.status)
                        report($sformatf("status got %0d want %0d",
                                         o_out_item.status, want.status));
                end
                if ($urandom_range(0, 39) == 0) begin
                    recv_calm = ~recv_calm;
                end
                stall_wait = draw_wait(recv_calm);
            end else if (stall_wait != 0) begin
                stall_wait--;
            end
            i_out_stall <= (stall_wait != 0);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial begin
        int n;
        int seg;
        int ins_pct;
        int lo_lv;
        int lv;
        bit focus;
        t_op op;
        logic [PAYLOAD_W-1:0] data;

        add_request(OP_REMOVE, 15, '1, 1'b0);
        add_request(OP_INSERT, 15, 32'h1234_5678, 1'b0);
        add_request(OP_INSERT, NUM_LEVELS, 32'h0bad_f00d, 1'b0);
        add_request(OP_INSERT, 0, '0, 1'b0);
        add_request(OP_INSERT, NUM_LEVELS - 1, '1, 1'b0);
        add_request(OP_REMOVE, 0, '0, 1'b0);
        add_request(OP_REMOVE, 8, 32'h5555_aaaa, 1'b0);
        add_request(OP_REMOVE, 3, 32'haaaa_5555, 1'b0);
        for (int k = 0; k <= LEVEL_DEPTH; k++) begin
            add_request(OP_INSERT, 4, $urandom, 1'b0);
        end

        n = 0;
        while (n < RANDOM_REQS) begin
            case ($urandom_range(0, 2))
                0: ins_pct = 20;
                1: ins_pct = 50;
                default: ins_pct = 85;
            endcase
            focus = 1'($urandom_range(0, 1));
            lo_lv = $urandom_range(0, NUM_LEVELS - 2);
            seg = $urandom_range(30, 80);
            for (int k = 0; k < seg && n < RANDOM_REQS; k++) begin
                if ($urandom_range(1, 100) <= ins_pct) begin
                    op = OP_INSERT;
                    if ($urandom_range(0, 15) == 0) begin
                        lv = $urandom_range(0, 15);
                    end else if (focus) begin
                        lv = $urandom_range(lo_lv, lo_lv + 1);
                    end else begin
                        lv = $urandom_range(0, NUM_LEVELS - 1);
                    end
                end else begin
                    op = OP_REMOVE;
                    lv = $urandom_range(0, 15);
                end
                case ($urandom_range(0, 9))
                    0: data = '0;
                    1: data = '1;
                    default: data = $urandom;
                endcase
                add_request(op, lv, data, n == 0 || $urandom_range(0, 150) == 0);
                n++;
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (request_backlog.size() != 0 || i_in_valid || results_seen != items_accepted) begin
            @(negedge i_clk);
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (predicted_results.size() != 0) begin
            report($sformatf("%0d results never arrived", predicted_results.size()));
        end
        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

FILE: multilevel_priority_fifo_top.f
+incdir+hdl
hdl/mlpf_pkg.sv
hdl/mlpf_ram.sv
hdl/mlpf_ctrl.sv
hdl/mlpf_dp.sv
hdl/multilevel_priority_fifo_top.sv
dv/testbench.sv
